### rtl/esd_pkg.sv
// esd_pkg: shared types for the escape sequence decoder
// result beat layout and the per-item push bundle between core and output queue
// no dependencies
`default_nettype none

package esd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_done;
    logic [LenW-1:0]  out_length;
  } result_t;

  // up to two results caused by one input beat, first one in slot 0
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

`default_nettype wire

### rtl/esd_core.sv
// esd_core: escape decoding mode machine, byte counter and capacity register
// depends on esd_pkg for result_t and push_t
`default_nettype none

module esd_core (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [esd_pkg::LenW-1:0] cfg_wdata_i,
  input  wire logic                    beat_i,
  input  wire logic [esd_pkg::ByteW-1:0] ch_i,
  output esd_pkg::push_t               push_o
);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_X,
    MODE_HEX1
  } mode_e;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChN      = 8'h6e;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] ByteLf   = 8'h0a;
  localparam logic [7:0] ByteCr   = 8'h0d;
  localparam logic [7:0] ByteTab  = 8'h09;
  localparam logic [15:0] CapReset = 16'd256;

  mode_e       mode_q, mode_d;
  logic [3:0]  nib_q, nib_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] cap_q;
  logic [15:0] limit;
  logic        room;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic        emit;
  logic [7:0]  emit_byte;

  assign limit = (cap_q == 16'd0) ? 16'd0 : cap_q - 16'd1;
  assign room  = cnt_q < limit;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (ch_i >= 8'h30 && ch_i <= 8'h39) begin
      hex_val = 4'(ch_i - 8'h30);
    end else if (ch_i >= 8'h61 && ch_i <= 8'h66) begin
      hex_val = 4'(ch_i - 8'h57);
    end else if (ch_i >= 8'h41 && ch_i <= 8'h46) begin
      hex_val = 4'(ch_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    mode_d    = mode_q;
    nib_d     = nib_q;
    cnt_d     = cnt_q;
    emit      = 1'b0;
    emit_byte = ch_i;
    push_o    = '0;
    if (beat_i) begin
      if (ch_i == ChNul) begin
        if (mode_q == MODE_ESC && room) begin
          push_o.v0 = 1'b1;
          push_o.r0 = '{out_byte: 8'h00, is_done: 1'b0, out_length: 16'd0};
          push_o.v1 = 1'b1;
          push_o.r1 = '{out_byte: 8'h00, is_done: 1'b1, out_length: cnt_q + 16'd1};
        end else begin
          push_o.v0 = 1'b1;
          push_o.r0 = '{out_byte: 8'h00, is_done: 1'b1, out_length: cnt_q};
        end
        mode_d = MODE_NORMAL;
        nib_d  = 4'd0;
        cnt_d  = 16'd0;
      end else if (!room) begin
        mode_d = MODE_NORMAL;
      end else begin
        unique case (mode_q)
          MODE_NORMAL: begin
            if (ch_i == ChBslash) mode_d = MODE_ESC;
            else emit = 1'b1;
          end
          MODE_ESC: begin
            mode_d = MODE_NORMAL;
            emit   = 1'b1;
            unique case (ch_i)
              ChN:     emit_byte = ByteLf;
              ChR:     emit_byte = ByteCr;
              ChT:     emit_byte = ByteTab;
              ChZero:  emit_byte = 8'h00;
              ChX: begin
                emit   = 1'b0;
                mode_d = MODE_X;
              end
              default: emit_byte = ch_i;
            endcase
          end
          MODE_X: begin
            if (hex_ok) begin
              nib_d  = hex_val;
              mode_d = MODE_HEX1;
            end else begin
              mode_d = MODE_NORMAL;
            end
          end
          MODE_HEX1: begin
            mode_d = MODE_NORMAL;
            if (hex_ok) begin
              emit      = 1'b1;
              emit_byte = {nib_q, hex_val};
            end else if (ch_i == ChBslash) begin
              mode_d = MODE_ESC;
            end else begin
              emit = 1'b1;
            end
          end
          default: mode_d = MODE_NORMAL;
        endcase
        if (emit) begin
          push_o.v0 = 1'b1;
          push_o.r0 = '{out_byte: emit_byte, is_done: 1'b0, out_length: 16'd0};
          cnt_d     = cnt_q + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      nib_q  <= 4'd0;
      cnt_q  <= 16'd0;
      cap_q  <= CapReset;
    end else begin
      mode_q <= mode_d;
      nib_q  <= nib_d;
      cnt_q  <= cnt_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

### rtl/esd_out_fifo.sv
// esd_out_fifo: result queue taking up to two beats per cycle, giving one
// depends on esd_pkg for result_t and push_t
`default_nettype none

module esd_out_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire esd_pkg::push_t push_i,
  input  wire logic           pop_i,
  output logic                full2_o,
  output logic                valid_o,
  output esd_pkg::result_t    head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  esd_pkg::result_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q, wr1, wr2;
  logic [CW-1:0] cnt_q;
  logic [1:0]    n_push;

  function automatic logic [AW-1:0] incr(input logic [AW-1:0] p);
    incr = (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign wr1     = incr(wr_q);
  assign wr2     = incr(wr1);
  assign n_push  = {1'b0, push_i.v0} + {1'b0, push_i.v1};
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign full2_o = cnt_q > CW'(Depth - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.v0) mem_q[wr_q] <= push_i.r0;
    if (push_i.v1) mem_q[wr1]  <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.v1) wr_q <= wr2;
      else if (push_i.v0) wr_q <= wr1;
      if (pop_i) rd_q <= incr(rd_q);
      cnt_q <= cnt_q + CW'(n_push) - CW'(pop_i);
    end
  end

endmodule

`default_nettype wire

### rtl/escape_sequence_decoder_unit.sv
// escape_sequence_decoder_unit: top level, decode core feeding a result queue
// depends on esd_pkg, esd_core, esd_out_fifo
//
//   channel | direction | handshake             | payload
//   in      | sink      | in_valid_i/in_stall_o | ch_i
//   out     | source    | out_valid_o/out_stall_i | out_byte_o, is_done_o, out_length_o
//   cfg     | sink      | cfg_we_i              | cfg_wdata_i (out_capacity)
//
// one input beat per cycle while in_stall_o is low; its results enter the queue at
// that edge and the first can be offered on the next cycle, one result beat per
// cycle unless out_stall_i; in_stall_o rises while fewer than two queue slots are free
// reset clears the mode, byte count, queue and sets out_capacity to 256
`default_nettype none

module escape_sequence_decoder_unit #(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [esd_pkg::LenW-1:0] cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [esd_pkg::ByteW-1:0] ch_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [esd_pkg::ByteW-1:0]     out_byte_o,
  output logic                          is_done_o,
  output logic [esd_pkg::LenW-1:0]      out_length_o
);

  esd_pkg::push_t   push;
  esd_pkg::result_t head;
  logic             full2;
  logic             beat;

  assign in_stall_o = full2;
  assign beat       = in_valid_i && !full2;

  esd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .beat_i      (beat),
    .ch_i        (ch_i),
    .push_o      (push)
  );

  esd_out_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_valid_o && !out_stall_i),
    .full2_o (full2),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign out_byte_o   = head.out_byte;
  assign is_done_o    = head.is_done;
  assign out_length_o = head.out_length;

endmodule

`default_nettype wire

### verif/esd_tracker_pkg.sv
`timescale 1ns / 100ps
// esd_tracker_pkg: character codes, decode modes and the expected-result tracker
// for the escape sequence decoder testbench; depends on esd_pkg

package esd_tracker_pkg;
  import esd_pkg::*;

  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChDigitZero = 8'h30;
  localparam logic [7:0] ChLowerX    = 8'h78;

  localparam logic [7:0] ByteLf  = 8'd10;
  localparam logic [7:0] ByteCr  = 8'd13;
  localparam logic [7:0] ByteTab = 8'd9;

  localparam logic [15:0] CapacityAtReset = 16'd256;

  typedef enum logic [1:0] {
    ModeNormal,
    ModeEsc,
    ModeHex1,
    ModeHex2
  } dec_mode_e;

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  class escape_tracker;
    logic [15:0] capacity;
    dec_mode_e   mode;
    logic [3:0]  high_nib;
    logic [15:0] count;
    result_t     decoded_q[$];
    int          mismatches;

    function new();
      capacity   = CapacityAtReset;
      mode       = ModeNormal;
      high_nib   = '0;
      count      = '0;
      mismatches = 0;
    endfunction

    function logic [15:0] byte_limit();
      return (capacity == 16'd0) ? 16'd0 : capacity - 16'd1;
    endfunction

    function void push_result(logic [7:0] b, logic d, logic [15:0] len);
      result_t r;
      r.out_byte   = b;
      r.is_done    = d;
      r.out_length = len;
      decoded_q.push_back(r);
    endfunction

    function void push_byte(logic [7:0] b);
      push_result(b, 1'b0, 16'd0);
      count = count + 16'd1;
    endfunction

    function void plain_char(logic [7:0] c);
      if (c == ChBackslash) begin
        mode = ModeEsc;
      end else begin
        push_byte(c);
        mode = ModeNormal;
      end
    endfunction

    function void note_char(logic [7:0] c);
      int h;
      if (c == ChNul) begin
        if (mode == ModeEsc && count < byte_limit()) push_byte(8'h00);
        push_result(8'h00, 1'b1, count);
        mode     = ModeNormal;
        high_nib = '0;
        count    = '0;
        return;
      end
      if (count >= byte_limit()) begin
        mode = ModeNormal;
        return;
      end
      h = hex_digit(c);
      case (mode)
        ModeNormal: plain_char(c);
        ModeEsc: begin
          mode = ModeNormal;
          case (c)
            ChLowerN:    push_byte(ByteLf);
            ChLowerR:    push_byte(ByteCr);
            ChLowerT:    push_byte(ByteTab);
            ChDigitZero: push_byte(8'h00);
            ChLowerX:    mode = ModeHex1;
            default:     push_byte(c);
          endcase
        end
        ModeHex1: begin
          if (h >= 0) begin
            high_nib = 4'(h);
            mode     = ModeHex2;
          end else begin
            mode = ModeNormal;
          end
        end
        default: begin
          mode = ModeNormal;
          if (h >= 0) push_byte({high_nib, 4'(h)});
          else plain_char(c);
        end
      endcase
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (decoded_q.size() == 0) begin
        $error("unexpected result beat: out_byte %0d is_done %0d out_length %0d",
               got.out_byte, got.is_done, got.out_length);
        mismatches++;
        return;
      end
      want = decoded_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0d, actual %0d", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.is_done !== want.is_done) begin
        $error("is_done: expected %0d, actual %0d", want.is_done, got.is_done);
        mismatches++;
      end
      if (got.out_length !== want.out_length) begin
        $error("out_length: expected %0d, actual %0d", want.out_length, got.out_length);
        mismatches++;
      end
    endfunction
  endclass

endpackage

### verif/tb.sv
`timescale 1ns / 100ps
// tb: drives character strings through escape_sequence_decoder_unit and checks
// every result beat against escape_tracker; depends on esd_pkg, esd_tracker_pkg

module tb;
  import esd_pkg::*;
  import esd_tracker_pkg::*;

  localparam int QuietLimit     = 2000;
  localparam int ItemsPerPhase  = 205;
  localparam int NumPhases      = 8;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [LenW-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [ByteW-1:0]  ch_i        = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ByteW-1:0]  out_byte_o;
  logic              is_done_o;
  logic [LenW-1:0]   out_length_o;

  escape_tracker tracker;
  int            send_idle_pct = 0;
  int            stall_pct     = 0;
  int            n_sent        = 0;
  int            quiet_cycles  = 0;

  logic [7:0] directed_chars [28] = '{
    ChBackslash, ChLowerN, ChBackslash, ChLowerR, ChBackslash, ChLowerT,
    ChBackslash, ChDigitZero, ChBackslash, ChBackslash,
    ChBackslash, ChLowerX, "a", "B", ChBackslash, "q", 8'hFF, ChNul,
    ChBackslash, ChLowerX, "g", ChBackslash, ChLowerX, "4", ChBackslash, ChLowerT,
    ChBackslash, ChNul
  };

  logic [15:0] phase_caps [NumPhases];

  escape_sequence_decoder_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .ch_i         (ch_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .is_done_o    (is_done_o),
    .out_length_o (out_length_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_beat({out_byte_o, is_done_o, out_length_o});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i       <= c;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_char(c);
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    if ($urandom_range(0, 1) == 0) return 8'("a" + v - 10);
    return 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (hex_digit(c) >= 0);
    return c;
  endfunction

  task automatic send_random_string();
    int n_tok;
    int kind;
    int ending;
    n_tok = $urandom_range(0, 16);
    repeat (n_tok) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        send_char(8'($urandom_range(1, 255)));
      end else if (kind < 55) begin
        send_char(ChBackslash);
        case ($urandom_range(0, 4))
          0:       send_char(ChLowerN);
          1:       send_char(ChLowerR);
          2:       send_char(ChLowerT);
          3:       send_char(ChDigitZero);
          default: send_char(ChBackslash);
        endcase
      end else if (kind < 70) begin
        send_char(ChBackslash);
        send_char(ChLowerX);
        send_char(rand_hex_char());
        send_char(rand_hex_char());
      end else if (kind < 78) begin
        send_char(ChBackslash);
        send_char(8'($urandom_range(1, 255)));
      end else if (kind < 86) begin
        send_char(ChBackslash);
        send_char(ChLowerX);
        send_char(rand_non_hex());
      end else if (kind < 94) begin
        send_char(ChBackslash);
        send_char(ChLowerX);
        send_char(rand_hex_char());
        send_char(rand_non_hex());
      end else begin
        send_char(8'($urandom_range(8'h20, 8'h7E)));
      end
    end
    ending = $urandom_range(0, 99);
    if (ending < 10) begin
      send_char(ChBackslash);
    end else if (ending < 15) begin
      send_char(ChBackslash);
      send_char(ChLowerX);
    end else if (ending < 20) begin
      send_char(ChBackslash);
      send_char(ChLowerX);
      send_char(rand_hex_char());
    end
    send_char(ChNul);
  endtask

  // called at a falling edge; returns once every expected beat has come
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (tracker.decoded_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.capacity = v;
    @(negedge clk_i);
  endtask

  initial begin
    tracker = new();
    phase_caps = '{16'd5, 16'd1, 16'd65535, 16'd0, 16'd3,
                   16'($urandom_range(2, 20)), 16'd256, 16'd12};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_chars[i]) send_char(directed_chars[i]);

    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      write_capacity(phase_caps[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      n_sent = 0;
      while (n_sent < ItemsPerPhase) send_random_string();
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.decoded_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
